@@ hw/rtl/nzf_pkg.sv @@
// Package for the nonzero winding scanline fill block.
// Holds field widths, operation and command codes, defaults and the command struct.
// No dependencies.
package nzf_pkg;

	localparam int CW = 20;              // coordinate width, signed fixed point
	localparam int ROW_W = 8;            // row, slice and column port width
	localparam int OP_W = 2;
	localparam int DYW = 26;             // row*2^F minus vertex y, signed
	localparam int DXW = CW + 1;         // difference of two coordinates, signed
	localparam int PW = DYW + DXW;       // product width, signed
	localparam int QW = CW + 2;          // quotient kept after the divide
	localparam int KIND_W = 2;

	localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	localparam int DEF_MAX_VERTICES = 128;
	localparam int DEF_MAX_CROSSINGS = 32;
	localparam int DEF_GRID_WIDTH = 256;
	localparam int DEF_GRID_HEIGHT = 256;
	localparam int DEF_FRACTION_BITS = 8;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [ROW_W-1:0]    row;
		logic [ROW_W-1:0]    slice;
		logic                row_ok;
	} cmd_t;

endpackage

@@ hw/rtl/nzf_front.sv @@
// Front end: input register, operation decode and row range check.
// Depends on nzf_pkg.
module nzf_front #(
	parameter int GRID_HEIGHT = nzf_pkg::DEF_GRID_HEIGHT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [nzf_pkg::OP_W-1:0]    operation,
	input  logic signed [nzf_pkg::CW-1:0] vertex_x,
	input  logic signed [nzf_pkg::CW-1:0] vertex_y,
	input  logic [nzf_pkg::ROW_W-1:0]   row_index,
	input  logic [nzf_pkg::ROW_W-1:0]   slice_tag,
	output logic                        push,
	output nzf_pkg::cmd_t               cmd,
	input  logic                        full
);
	import nzf_pkg::*;

	logic v_q;
	cmd_t c_q;
	cmd_t c_nx;
	logic accept;

	assign in_stall = v_q & full;
	assign accept = in_valid & ~in_stall;
	assign push = v_q & ~full;
	assign cmd = c_q;

	always_comb begin
		c_nx.x = vertex_x;
		c_nx.y = vertex_y;
		c_nx.row = row_index;
		c_nx.slice = slice_tag;
		c_nx.row_ok = (row_index != '0) && (int'(row_index) <= GRID_HEIGHT - 2);
		unique case (operation)
			OP_FIRST:  c_nx.kind = KIND_FIRST;
			OP_APPEND: c_nx.kind = KIND_APPEND;
			OP_QUERY:  c_nx.kind = KIND_QUERY;
			default:   c_nx.kind = KIND_FIRST;
		endcase
	end

	// drop the unused operation code here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (accept) begin
			v_q <= (operation != OP_NOP);
		end else if (push) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q <= c_nx;
		end
	end

endmodule

@@ hw/rtl/nzf_fifo.sv @@
// Two-entry command queue between the front and back ends.
// Depends on nzf_pkg.
module nzf_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nzf_pkg::cmd_t wdata,
	input  logic          pop,
	output nzf_pkg::cmd_t rdata,
	output logic          full,
	output logic          empty
);
	import nzf_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

@@ hw/rtl/nzf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module nzf_div #(
	parameter int NW = 46,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     sh;
	logic [DW+1:0]   diff;

	assign busy = busy_q;
	assign quo = quo_q;
	assign rem = rem_q;
	assign sh = {rem_q, quo_q[NW-1]};
	assign diff = {1'b0, sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(NW - 1)) busy_q <= 1'b0;
		end
	end

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW+1]) rem_q <= diff[DW-1:0];
			else rem_q <= sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ~diff[DW+1]};
		end
	end

endmodule

@@ hw/rtl/nzf_back.sv @@
// Back end: vertex memory, edge walk, crossing solve, sorted crossing cells,
// winding accumulation and span output register. Depends on nzf_pkg, nzf_div.
module nzf_back #(
	parameter int MAX_VERTICES = nzf_pkg::DEF_MAX_VERTICES,
	parameter int MAX_CROSSINGS = nzf_pkg::DEF_MAX_CROSSINGS,
	parameter int GRID_WIDTH = nzf_pkg::DEF_GRID_WIDTH,
	parameter int FRACTION_BITS = nzf_pkg::DEF_FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  nzf_pkg::cmd_t             cmd,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [nzf_pkg::ROW_W-1:0] out_row,
	output logic [nzf_pkg::ROW_W-1:0] out_slice,
	output logic [nzf_pkg::ROW_W-1:0] span_start,
	output logic [nzf_pkg::ROW_W-1:0] span_end,
	output logic                      span_valid,
	output logic                      crossings_dropped,
	output logic                      last_span
);
	import nzf_pkg::*;

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int MW = $clog2(MAX_CROSSINGS + 1);
	localparam int WW = MW + 1;
	localparam int NW = PW - 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_DIVS = 4'd4;
	localparam logic [3:0] S_DIVW = 4'd5;
	localparam logic [3:0] S_FIX  = 4'd6;
	localparam logic [3:0] S_INS  = 4'd7;
	localparam logic [3:0] S_NXT  = 4'd8;
	localparam logic [3:0] S_SPAN = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]          st_q;
	logic [VCW-1:0]      vcount_q;
	logic [VAW-1:0]      k_q;
	logic [VAW-1:0]      k2;
	logic                last_edge;
	logic [2*CW-1:0]     vmem_q [MAX_VERTICES];
	logic [2*CW-1:0]     rda_q;
	logic [2*CW-1:0]     rdb_q;
	logic                wr_en;
	logic [VAW-1:0]      wr_addr;

	logic [ROW_W-1:0]    row_q;
	logic [ROW_W-1:0]    slice_q;
	logic [MW-1:0]       m_q;
	logic                drop_q;
	logic signed [WW-1:0] wind_q;
	logic                pend_q;
	logic [ROW_W-1:0]    pstart_q;
	logic [ROW_W-1:0]    pend_end_q;

	logic signed [DYW-1:0] fy;
	logic signed [DYW-1:0] ay_e;
	logic signed [DYW-1:0] by_e;
	logic signed [CW-1:0]  ax;
	logic signed [CW-1:0]  ay;
	logic signed [CW-1:0]  bx;
	logic signed [CW-1:0]  by;
	logic                  crosses;

	logic signed [DYW-1:0] dy_s;
	logic signed [DXW-1:0] dx_s;
	logic signed [DXW-1:0] den_s;
	logic signed [CW-1:0]  ax_s;
	logic                  dir_s;
	logic signed [PW-1:0]  prod_s;
	logic                  nsign_s;
	logic signed [CW-1:0]  x_s;

	logic            div_start;
	logic [NW-1:0]   div_num;
	logic [DXW-1:0]  div_den;
	logic            div_busy;
	logic [NW-1:0]   div_quo;
	logic [DXW-1:0]  div_rem;
	logic [PW-1:0]   prod_mag;
	logic [QW-1:0]   qs;

	logic signed [CW-1:0] cx_q [MAX_CROSSINGS];
	logic                 cd_q [MAX_CROSSINGS];
	logic                 le [MAX_CROSSINGS];

	logic signed [WW-1:0] wind_nx;
	logic signed [CW:0]   xa;
	logic signed [CW:0]   xb;
	logic signed [CW:0]   xa_c;
	logic signed [CW:0]   xb_c;
	logic                 cand;
	logic                 slot;
	logic                 advance;
	logic                 emit;
	logic                 emit_valid;

	assign pop = (st_q == S_IDLE) && !empty;
	assign last_edge = (VCW'(k_q) + VCW'(1)) == vcount_q;
	assign k2 = last_edge ? '0 : k_q + 1'b1;

	// vertex memory, two registered read ports
	assign wr_en = pop && ((cmd.kind == KIND_FIRST) ||
		((cmd.kind == KIND_APPEND) && (vcount_q < VCW'(MAX_VERTICES))));
	assign wr_addr = (cmd.kind == KIND_FIRST) ? '0 : vcount_q[VAW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) vmem_q[wr_addr] <= {cmd.x, cmd.y};
		rda_q <= vmem_q[k_q];
		rdb_q <= vmem_q[k2];
	end

	assign ax = rda_q[2*CW-1:CW];
	assign ay = rda_q[CW-1:0];
	assign bx = rdb_q[2*CW-1:CW];
	assign by = rdb_q[CW-1:0];
	assign fy = DYW'(row_q) <<< FRACTION_BITS;
	assign ay_e = DYW'(ay);
	assign by_e = DYW'(by);
	assign crosses = (ay_e > fy) != (by_e > fy);

	// crossing solve: divide magnitudes, fix the sign for a floor afterwards
	assign prod_mag = prod_s[PW-1] ? -prod_s : prod_s;
	assign div_start = (st_q == S_DIVS);
	assign div_num = prod_mag[NW-1:0];
	assign div_den = den_s[DXW-1] ? DXW'(-den_s) : DXW'(den_s);

	nzf_div #(.NW(NW), .DW(DXW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo), .rem(div_rem)
	);

	assign qs = nsign_s ? (~div_quo[QW-1:0] + QW'(div_rem == '0)) : div_quo[QW-1:0];

	// sorted insert: equal x goes after existing entries
	always_comb begin
		for (int i = 0; i < MAX_CROSSINGS; i++) begin
			le[i] = (MW'(i) < m_q) && (cx_q[i] <= x_s);
		end
	end

	// span step over the two lowest cells
	assign wind_nx = cd_q[0] ? wind_q + WW'(1) : wind_q - WW'(1);
	assign xa = ((CW+1)'(cx_q[0]) + (CW+1)'((1 << FRACTION_BITS) - 1)) >>> FRACTION_BITS;
	assign xb = (CW+1)'(cx_q[1]) >>> FRACTION_BITS;
	assign xa_c = (xa < (CW+1)'(1)) ? (CW+1)'(1) : xa;
	assign xb_c = (xb > (CW+1)'(GRID_WIDTH - 2)) ? (CW+1)'(GRID_WIDTH - 2) : xb;
	assign cand = (wind_nx != '0) && (xa_c <= xb_c);
	assign slot = !out_valid || !out_stall;
	assign advance = (st_q == S_SPAN) && (m_q >= MW'(2)) && (!(cand && pend_q) || slot);
	assign emit = (advance && cand && pend_q) || ((st_q == S_FIN) && slot);
	assign emit_valid = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vcount_q <= '0;
			k_q <= '0;
			m_q <= '0;
			drop_q <= 1'b0;
			wind_q <= '0;
			pend_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.kind)
							KIND_FIRST: vcount_q <= VCW'(1);
							KIND_APPEND: begin
								if (vcount_q < VCW'(MAX_VERTICES)) vcount_q <= vcount_q + 1'b1;
							end
							KIND_QUERY: begin
								k_q <= '0;
								m_q <= '0;
								drop_q <= 1'b0;
								wind_q <= '0;
								pend_q <= 1'b0;
								if (!cmd.row_ok || vcount_q < VCW'(2)) st_q <= S_FIN;
								else st_q <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					if (crosses && m_q < MW'(MAX_CROSSINGS)) st_q <= S_MUL;
					else begin
						if (crosses) drop_q <= 1'b1;
						st_q <= S_NXT;
					end
				end
				S_MUL: st_q <= S_DIVS;
				S_DIVS: st_q <= S_DIVW;
				S_DIVW: if (!div_busy) st_q <= S_FIX;
				S_FIX: st_q <= S_INS;
				S_INS: begin
					m_q <= m_q + 1'b1;
					st_q <= S_NXT;
				end
				S_NXT: begin
					if (last_edge) st_q <= S_SPAN;
					else begin
						k_q <= k_q + 1'b1;
						st_q <= S_RD;
					end
				end
				S_SPAN: begin
					if (m_q < MW'(2)) st_q <= S_FIN;
					else if (advance) begin
						wind_q <= wind_nx;
						m_q <= m_q - 1'b1;
						if (cand) pend_q <= 1'b1;
					end
				end
				S_FIN: if (slot) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers and crossing cells
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && pop) begin
			row_q <= cmd.row;
			slice_q <= cmd.slice;
		end
		if (st_q == S_CHK) begin
			dy_s <= fy - ay_e;
			dx_s <= DXW'(bx) - DXW'(ax);
			den_s <= DXW'(by) - DXW'(ay);
			ax_s <= ax;
			dir_s <= by > ay;
		end
		if (st_q == S_MUL) prod_s <= dy_s * dx_s;
		if (st_q == S_DIVS) nsign_s <= prod_s[PW-1] ^ den_s[DXW-1];
		if (st_q == S_FIX) x_s <= CW'(QW'(ax_s) + qs);
		if (advance && cand) begin
			pstart_q <= xa_c[ROW_W-1:0];
			pend_end_q <= xb_c[ROW_W-1:0];
		end
		if (st_q == S_INS) begin
			for (int i = 0; i < MAX_CROSSINGS; i++) begin
				if (!le[i]) begin
					if (i == 0 || le[i == 0 ? 0 : i-1]) begin
						cx_q[i] <= x_s;
						cd_q[i] <= dir_s;
					end else begin
						cx_q[i] <= cx_q[i == 0 ? 0 : i-1];
						cd_q[i] <= cd_q[i == 0 ? 0 : i-1];
					end
				end
			end
		end else if (advance) begin
			for (int i = 0; i < MAX_CROSSINGS - 1; i++) begin
				cx_q[i] <= cx_q[i+1];
				cd_q[i] <= cd_q[i+1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row <= row_q;
			out_slice <= slice_q;
			span_start <= emit_valid ? pstart_q : '0;
			span_end <= emit_valid ? pend_end_q : '0;
			span_valid <= emit_valid;
			crossings_dropped <= drop_q;
			last_span <= (st_q == S_FIN);
		end
	end

endmodule

@@ hw/rtl/nonzero_winding_scanline_fill.sv @@
// Nonzero winding scanline fill, top level. Depends on nzf_pkg, nzf_front,
// nzf_fifo, nzf_back (which holds nzf_div).
// A vertex transaction passes the input register and the queue into the vertex memory;
// a row query walks each edge, with a 46-step serial divide per crossing edge, then the
// sorted crossings. Throughput: vertex loads 1 per cycle while the queue has room, queries
// one at a time in the back end. Reset (arst_n low, async) empties the queue, clears count.
module nonzero_winding_scanline_fill #(
	parameter int MAX_VERTICES = nzf_pkg::DEF_MAX_VERTICES,
	parameter int MAX_CROSSINGS = nzf_pkg::DEF_MAX_CROSSINGS,
	parameter int GRID_WIDTH = nzf_pkg::DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = nzf_pkg::DEF_GRID_HEIGHT,
	parameter int FRACTION_BITS = nzf_pkg::DEF_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nzf_pkg::OP_W-1:0]      operation,
	input  logic signed [nzf_pkg::CW-1:0] vertex_x,
	input  logic signed [nzf_pkg::CW-1:0] vertex_y,
	input  logic [nzf_pkg::ROW_W-1:0]     row_index,
	input  logic [nzf_pkg::ROW_W-1:0]     slice_tag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nzf_pkg::ROW_W-1:0]     out_row,
	output logic [nzf_pkg::ROW_W-1:0]     out_slice,
	output logic [nzf_pkg::ROW_W-1:0]     span_start,
	output logic [nzf_pkg::ROW_W-1:0]     span_end,
	output logic                          span_valid,
	output logic                          crossings_dropped,
	output logic                          last_span
);
	import nzf_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t f_cmd;
	cmd_t b_cmd;

	// Front: register the transaction, decode it, drop the unused code.
	nzf_front #(.GRID_HEIGHT(GRID_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.row_index(row_index), .slice_tag(slice_tag),
		.push(push), .cmd(f_cmd), .full(full)
	);

	// Queue: lets the front take vertices while a query runs, until it fills.
	nzf_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(f_cmd),
		.pop(pop), .rdata(b_cmd), .full(full), .empty(empty)
	);

	// Back: store vertices, solve crossings, emit spans.
	nzf_back #(
		.MAX_VERTICES(MAX_VERTICES), .MAX_CROSSINGS(MAX_CROSSINGS),
		.GRID_WIDTH(GRID_WIDTH), .FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .cmd(b_cmd), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
		.out_slice(out_slice), .span_start(span_start), .span_end(span_end),
		.span_valid(span_valid), .crossings_dropped(crossings_dropped),
		.last_span(last_span)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> full) else $error("input stalled with queue space");

endmodule
